// ----- rtl/core/nnsc_pkg.sv -----
package nnsc_pkg;

  localparam int MAX_VECTORS = 256;
  localparam int MAX_LENGTH  = 16;
  localparam int STORE_DEPTH = MAX_VECTORS * MAX_LENGTH;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int ELEM_W = $clog2(STORE_DEPTH + 1);
  localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
  localparam int VCNT_W = $clog2(MAX_VECTORS + 1);
  localparam int SUM_W  = $clog2(MAX_LENGTH * 65535 + 1);

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 5;
  localparam int CMD_W    = 2;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PARTIAL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0]  self_count_a;
    logic [COUNT_W-1:0]  self_count_b;
    logic [COUNT_W-1:0]  vectors_a;
    logic [COUNT_W-1:0]  vectors_b;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// ----- rtl/core/nnsc_if.sv -----
interface nnsc_in_if;
  logic                              valid;
  logic                              ready;
  logic [nnsc_pkg::CMD_W-1:0]        cmd;
  logic signed [nnsc_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink (input valid, input cmd, input sample, output ready);
endinterface

interface nnsc_out_if;
  logic                               valid;
  logic                               ready;
  logic [nnsc_pkg::COUNT_W-1:0]       self_count_a;
  logic [nnsc_pkg::COUNT_W-1:0]       self_count_b;
  logic [nnsc_pkg::COUNT_W-1:0]       vectors_a;
  logic [nnsc_pkg::COUNT_W-1:0]       vectors_b;
  logic [nnsc_pkg::STATUS_W-1:0]      status;

  modport source (output valid, output self_count_a, output self_count_b,
                  output vectors_a, output vectors_b, output status, input ready);
  modport sink (input valid, input self_count_a, input self_count_b,
                input vectors_a, input vectors_b, input status, output ready);
endinterface

// ----- rtl/core/nearest_neighbour_self_class_count_unit.sv -----
// nearest neighbour self-class counter, L1 distance
// in_ch carries commands: load a sample into class A, load into class B, or
// evaluate. loads give no result; a load into a full class store is dropped
// and flagged as overflow.
// evaluate reads both class stores and sends one transfer on out_ch with the
// self-classed counts, vector counts and status, then both classes are empty.
// an evaluate first splits the element counts into vectors, then walks the
// vector pairs; the pair walk is bound by the two read ports of each class
// memory, one element per cycle. while an evaluate runs in_ch.ready is low.
// cfg_we/cfg_wdata set the vector length (0 acts as 1, above the maximum
// acts as the maximum); write it only while the block is idle.
// the result sits in an output register: loads keep being accepted while it
// waits, and a following evaluate holds in its last step until out_ch is free.
// rst_n is synchronous: element counts, the overflow flag and the output valid
// clear, vector length goes to 16, the store contents are left as they are.
module nearest_neighbour_self_class_count_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  nnsc_in_if.sink                    in_ch,
  nnsc_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [nnsc_pkg::CFG_W-1:0] cfg_wdata
);
  import nnsc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_PAIR  = 3'd4;
  localparam logic [2:0] S_LAST  = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]             state_r;
  logic [CFG_W-1:0]       vlen_r;
  logic [LEN_W-1:0]       len;
  logic [ELEM_W-1:0]      elem_a_r, elem_b_r;
  logic                   ovf_r, over_r, partial_r;
  logic [ELEM_W-1:0]      dq_a_r, dq_b_r;
  logic [LEN_W-1:0]       dr_a_r, dr_b_r;
  logic [$clog2(ELEM_W)-1:0] div_cnt_r;
  logic [VCNT_W-1:0]      na_r, nb_r, j_r, i_r, cnt_a_r, cnt_b_r;
  logic                   cls_r, phase_r, have_r;
  logic [LEN_W-1:0]       k_r;
  logic [SUM_W-1:0]       acc_r, smin_r;
  logic                   rd_v_r;
  result_t                out_r;
  logic                   out_v_r;

  logic [ADDR_W-1:0]      addr_p, addr_q;
  logic [SAMPLE_W-1:0]    mem_a [STORE_DEPTH];
  logic [SAMPLE_W-1:0]    mem_b [STORE_DEPTH];
  logic [SAMPLE_W-1:0]    rd_ap_r, rd_aq_r, rd_bp_r, rd_bq_r;
  logic [SAMPLE_W-1:0]    dat_p, dat_q;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W-1:0]    absd;
  logic                   acc_in;
  logic                   wr_a, wr_b;
  logic [VCNT_W-1:0]      n_own, n_oth;
  logic [LEN_W:0]         rsh_a, rsh_b;
  logic                   ge_a, ge_b;
  logic [VCNT_W+LEN_W-1:0] prod_p, prod_q;
  logic                   out_free;

  // effective vector length
  always_comb begin
    if (vlen_r == '0) begin
      len = LEN_W'(1);
    end else if (32'(vlen_r) > MAX_LENGTH) begin
      len = LEN_W'(MAX_LENGTH);
    end else begin
      len = LEN_W'(vlen_r);
    end
  end

  assign acc_in  = in_ch.valid && in_ch.ready;
  assign wr_a    = acc_in && (in_ch.cmd == CMD_LOAD_A) && (elem_a_r != ELEM_W'(STORE_DEPTH));
  assign wr_b    = acc_in && (in_ch.cmd == CMD_LOAD_B) && (elem_b_r != ELEM_W'(STORE_DEPTH));
  assign in_ch.ready = (state_r == S_IDLE);

  assign prod_p = j_r * len;
  assign prod_q = i_r * len;
  assign addr_p = ADDR_W'(prod_p + k_r);
  assign addr_q = ADDR_W'(prod_q + k_r);

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[elem_a_r[ADDR_W-1:0]] <= in_ch.sample;
    end
    rd_ap_r <= mem_a[addr_p];
    rd_aq_r <= mem_a[addr_q];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[elem_b_r[ADDR_W-1:0]] <= in_ch.sample;
    end
    rd_bp_r <= mem_b[addr_p];
    rd_bq_r <= mem_b[addr_q];
  end

  // own vector on port p, compared vector on port q
  assign dat_p = cls_r ? rd_bp_r : rd_ap_r;
  assign dat_q = (cls_r ^ phase_r) ? rd_bq_r : rd_aq_r;
  assign diff  = $signed({dat_p[SAMPLE_W-1], dat_p}) - $signed({dat_q[SAMPLE_W-1], dat_q});
  assign absd  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : SAMPLE_W'(diff);

  assign n_own = cls_r ? nb_r : na_r;
  assign n_oth = cls_r ? na_r : nb_r;

  // one restoring divide step per cycle for each class
  assign rsh_a = {dr_a_r, dq_a_r[ELEM_W-1]};
  assign rsh_b = {dr_b_r, dq_b_r[ELEM_W-1]};
  assign ge_a  = rsh_a >= {1'b0, len};
  assign ge_b  = rsh_b >= {1'b0, len};

  assign out_free = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vlen_r   <= CFG_W'(16);
      elem_a_r <= '0;
      elem_b_r <= '0;
      ovf_r    <= 1'b0;
      out_v_r  <= 1'b0;
      rd_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        vlen_r <= cfg_wdata;
      end
      // a new result loaded in S_OUT takes the place of the one leaving
      if (out_v_r && out_ch.ready && (state_r != S_OUT)) begin
        out_v_r <= 1'b0;
      end
      rd_v_r <= (state_r == S_PAIR);
      if (rd_v_r) begin
        acc_r <= acc_r + SUM_W'(absd);
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            case (in_ch.cmd)
              CMD_LOAD_A: begin
                if (wr_a) elem_a_r <= elem_a_r + 1'b1;
                else ovf_r <= 1'b1;
              end
              CMD_LOAD_B: begin
                if (wr_b) elem_b_r <= elem_b_r + 1'b1;
                else ovf_r <= 1'b1;
              end
              CMD_EVAL: begin
                dq_a_r    <= elem_a_r;
                dq_b_r    <= elem_b_r;
                dr_a_r    <= '0;
                dr_b_r    <= '0;
                div_cnt_r <= '0;
                over_r    <= ovf_r;
                elem_a_r  <= '0;
                elem_b_r  <= '0;
                ovf_r     <= 1'b0;
                state_r   <= S_DIV;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          dq_a_r    <= {dq_a_r[ELEM_W-2:0], ge_a};
          dq_b_r    <= {dq_b_r[ELEM_W-2:0], ge_b};
          dr_a_r    <= ge_a ? LEN_W'(rsh_a - {1'b0, len}) : LEN_W'(rsh_a);
          dr_b_r    <= ge_b ? LEN_W'(rsh_b - {1'b0, len}) : LEN_W'(rsh_b);
          div_cnt_r <= div_cnt_r + 1'b1;
          if (32'(div_cnt_r) == ELEM_W - 1) state_r <= S_FIN;
        end
        S_FIN: begin
          over_r <= over_r || (32'(dq_a_r) > MAX_VECTORS) || (32'(dq_b_r) > MAX_VECTORS);
          if (32'(dq_a_r) > MAX_VECTORS) begin
            na_r <= VCNT_W'(MAX_VECTORS);
          end else begin
            na_r <= VCNT_W'(dq_a_r);
          end
          if (32'(dq_b_r) > MAX_VECTORS) begin
            nb_r <= VCNT_W'(MAX_VECTORS);
          end else begin
            nb_r <= VCNT_W'(dq_b_r);
          end
          partial_r <= (dr_a_r != '0) || (dr_b_r != '0);
          cls_r   <= 1'b0;
          j_r     <= '0;
          i_r     <= '0;
          phase_r <= 1'b0;
          have_r  <= 1'b0;
          smin_r  <= '0;
          cnt_a_r <= '0;
          cnt_b_r <= '0;
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          if (j_r >= n_own) begin
            if (!cls_r) begin
              cls_r   <= 1'b1;
              j_r     <= '0;
              i_r     <= '0;
              phase_r <= 1'b0;
              have_r  <= 1'b0;
              smin_r  <= '0;
            end else begin
              state_r <= S_OUT;
            end
          end else if (!phase_r) begin
            if (i_r == j_r) begin
              i_r <= i_r + 1'b1;
            end else if (i_r >= n_own) begin
              if (!have_r) begin
                // alone in its class: own distance is zero, always self-classed
                if (cls_r) cnt_b_r <= cnt_b_r + 1'b1;
                else cnt_a_r <= cnt_a_r + 1'b1;
                j_r <= j_r + 1'b1;
                i_r <= '0;
              end else begin
                phase_r <= 1'b1;
                i_r     <= '0;
              end
            end else begin
              k_r     <= '0;
              acc_r   <= '0;
              state_r <= S_PAIR;
            end
          end else begin
            if (i_r >= n_oth) begin
              if (cls_r) cnt_b_r <= cnt_b_r + 1'b1;
              else cnt_a_r <= cnt_a_r + 1'b1;
              j_r     <= j_r + 1'b1;
              i_r     <= '0;
              phase_r <= 1'b0;
              have_r  <= 1'b0;
              smin_r  <= '0;
            end else begin
              k_r     <= '0;
              acc_r   <= '0;
              state_r <= S_PAIR;
            end
          end
        end
        S_PAIR: begin
          k_r <= k_r + 1'b1;
          if (k_r == len - 1'b1) state_r <= S_LAST;
        end
        S_LAST: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (!phase_r) begin
            if (!have_r || acc_r < smin_r) begin
              smin_r <= acc_r;
              have_r <= 1'b1;
            end
            i_r <= i_r + 1'b1;
          end else if (acc_r < smin_r) begin
            // other class strictly closer: not self-classed
            j_r     <= j_r + 1'b1;
            i_r     <= '0;
            phase_r <= 1'b0;
            have_r  <= 1'b0;
            smin_r  <= '0;
          end else begin
            i_r <= i_r + 1'b1;
          end
          state_r <= S_SETUP;
        end
        S_OUT: begin
          if (out_free) begin
            out_r.self_count_a <= COUNT_W'(cnt_a_r);
            out_r.self_count_b <= COUNT_W'(cnt_b_r);
            out_r.vectors_a    <= COUNT_W'(na_r);
            out_r.vectors_b    <= COUNT_W'(nb_r);
            if (over_r) out_r.status <= ST_OVERFLOW;
            else if (partial_r) out_r.status <= ST_PARTIAL;
            else if (na_r == '0 || nb_r == '0) out_r.status <= ST_EMPTY;
            else out_r.status <= ST_OK;
            out_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.self_count_a = out_r.self_count_a;
  assign out_ch.self_count_b = out_r.self_count_b;
  assign out_ch.vectors_a    = out_r.vectors_a;
  assign out_ch.vectors_b    = out_r.vectors_b;
  assign out_ch.status       = out_r.status;

  a_eval_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && in_ch.cmd == CMD_EVAL) |=> (elem_a_r == '0 && elem_b_r == '0 && !ovf_r))
    else $error("element counts not cleared by evaluate");

  a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && in_ch.cmd == CMD_LOAD_A && elem_a_r == ELEM_W'(STORE_DEPTH)) |=> ovf_r)
    else $error("load into full store not flagged");

  a_self_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (cnt_a_r <= na_r && cnt_b_r <= nb_r))
    else $error("self count exceeds vector count");

  a_vec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETUP) |-> (32'(na_r) <= MAX_VECTORS && 32'(nb_r) <= MAX_VECTORS))
    else $error("vector count above capacity");

endmodule
